/* design/ced_pkg.sv */
// ----------------------------------------------------------------------------
// ced_pkg
// Shared types and constants of the C escape character decoder.
// ----------------------------------------------------------------------------
package ced_pkg;

  localparam int QUEUE_DEPTH_DEF = 2;
  localparam int RES_DEPTH       = 4;
  localparam int RES_PW          = 2;
  localparam int RES_CW          = 3;

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_ESC    = 3'd1,
    MODE_HEX1   = 3'd2,
    MODE_HEXRUN = 3'd3,
    MODE_OCTRUN = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_NO_HEX = 2'd2,
    ST_RANGE  = 2'd3
  } status_t;

  localparam logic [7:0] CH_BEL   = 8'h07;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_SLASH = 8'h5C;
  localparam logic [7:0] CH_MAX   = 8'h7F;

  typedef struct packed {
    logic [7:0] byte_val;
    logic       is_zero;
    logic       is_bslash;
    logic       is_x;
    logic       hex_ok;
    logic [3:0] hex_val;
    logic       oct_ok;
    logic       esc_simple;
    logic [7:0] esc_char;
  } item_t;

  typedef struct packed {
    logic [7:0] ch;
    status_t    st;
    logic [7:0] used;
    logic       last;
  } result_t;

endpackage

/* design/ced_front.sv */
// ----------------------------------------------------------------------------
// ced_front
// Input stage: registers each text byte and classifies it for the parser.
// ----------------------------------------------------------------------------
module ced_front
  import ced_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] text_byte,
  output logic       f_valid,
  output item_t      f_item,
  input  logic       q_ready
);

  item_t cls;
  logic  load;

  always_comb begin
    cls            = '0;
    cls.byte_val   = text_byte;
    cls.is_zero    = (text_byte == 8'h00);
    cls.is_bslash  = (text_byte == CH_SLASH);
    cls.is_x       = (text_byte == "x");
    cls.oct_ok     = (text_byte >= "0") && (text_byte <= "7");
    cls.esc_simple = 1'b1;
    if ((text_byte >= "0") && (text_byte <= "9")) begin
      cls.hex_ok  = 1'b1;
      cls.hex_val = text_byte[3:0];
    end else if (((text_byte >= "a") && (text_byte <= "f")) ||
                 ((text_byte >= "A") && (text_byte <= "F"))) begin
      cls.hex_ok  = 1'b1;
      cls.hex_val = text_byte[3:0] + 4'd9;
    end
    case (text_byte)
      "a":      cls.esc_char = CH_BEL;
      "b":      cls.esc_char = CH_BS;
      "f":      cls.esc_char = CH_FF;
      "n":      cls.esc_char = CH_LF;
      "r":      cls.esc_char = CH_CR;
      "t":      cls.esc_char = CH_TAB;
      "v":      cls.esc_char = CH_VT;
      default:  cls.esc_char = text_byte;
    endcase
    if (cls.is_x || cls.oct_ok) begin
      cls.esc_simple = 1'b0;
    end
  end

  assign in_stall = f_valid && !q_ready;
  assign load     = !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (load) begin
      f_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      f_item <= cls;
    end
  end

endmodule

/* design/ced_queue.sv */
// ----------------------------------------------------------------------------
// ced_queue
// Short queue of classified bytes between the input stage and the parser.
// ----------------------------------------------------------------------------
module ced_queue
  import ced_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  ready,
  output logic  q_valid,
  output item_t q_item,
  input  logic  pop
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

  item_t         entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign ready   = (count != CW'(DEPTH));
  assign q_valid = (count != '0);
  assign q_item  = entries[rd_ptr];
  assign do_push = push && ready;
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!do_push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

/* design/ced_back.sv */
// ----------------------------------------------------------------------------
// ced_back
// Parser: tracks the escape mode, accumulates digit runs and queues results.
// ----------------------------------------------------------------------------
module ced_back
  import ced_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  item_t             q_item,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic signed [7:0] decoded_char,
  output logic [1:0]        status,
  output logic [7:0]        bytes_used,
  output logic              last_of_run
);

  mode_t             mode;
  mode_t             mode_next;
  logic [7:0]        digit_value;
  logic [7:0]        digit_value_next;
  logic              value_overflowed;
  logic              value_overflowed_next;
  logic [7:0]        byte_count;
  logic [7:0]        byte_count_next;

  result_t           res_mem [RES_DEPTH];
  logic [RES_PW-1:0] wr_ptr;
  logic [RES_PW-1:0] rd_ptr;
  logic [RES_CW-1:0] res_count;

  mode_t             idle_mode;
  logic              digit_ok;
  logic [11:0]       shifted;
  logic [11:0]       acc;
  logic [7:0]        count_inc;
  logic              do_idle;
  logic              pre_v;
  logic              idle_v;
  result_t           pre_r;
  result_t           idle_r;
  result_t           slot0;
  result_t           slot1;
  logic [1:0]        n_write;
  logic              take;

  assign pop  = q_valid && (res_count <= RES_CW'(RES_DEPTH - 2));
  assign take = out_valid && !out_stall;

  assign idle_mode = q_item.is_bslash ? MODE_ESC : MODE_IDLE;
  assign digit_ok  = (mode == MODE_HEXRUN) ? q_item.hex_ok : q_item.oct_ok;
  assign shifted   = (mode == MODE_HEXRUN) ? {digit_value, 4'h0} : {1'b0, digit_value, 3'h0};
  assign acc       = shifted + {8'h00, q_item.hex_val};
  assign count_inc = (byte_count == 8'hFF) ? byte_count : byte_count + 8'd1;

  always_comb begin
    case (mode)
      MODE_ESC: begin
        if (q_item.is_x) begin
          mode_next = MODE_HEX1;
        end else if (q_item.oct_ok) begin
          mode_next = MODE_OCTRUN;
        end else begin
          mode_next = MODE_IDLE;
        end
      end
      MODE_HEX1:   mode_next = q_item.hex_ok ? MODE_HEXRUN : idle_mode;
      MODE_HEXRUN: mode_next = q_item.hex_ok ? MODE_HEXRUN : idle_mode;
      MODE_OCTRUN: mode_next = q_item.oct_ok ? MODE_OCTRUN : idle_mode;
      default:     mode_next = idle_mode;
    endcase
  end

  always_comb begin
    digit_value_next      = digit_value;
    value_overflowed_next = value_overflowed;
    byte_count_next       = byte_count;
    do_idle               = 1'b0;
    pre_v                 = 1'b0;
    pre_r                 = '0;
    case (mode)
      MODE_ESC: begin
        if (q_item.is_x) begin
          byte_count_next = 8'd2;
        end else if (q_item.oct_ok) begin
          digit_value_next      = {4'h0, q_item.hex_val};
          value_overflowed_next = 1'b0;
          byte_count_next       = 8'd2;
        end else begin
          pre_v            = 1'b1;
          pre_r.ch         = q_item.esc_char;
          pre_r.st         = ST_OK;
          pre_r.used       = 8'd2;
          digit_value_next = 8'h00;
          byte_count_next  = 8'h00;
        end
      end
      MODE_HEX1: begin
        if (q_item.hex_ok) begin
          digit_value_next      = {4'h0, q_item.hex_val};
          value_overflowed_next = 1'b0;
          byte_count_next       = 8'd3;
        end else begin
          pre_v      = 1'b1;
          pre_r.st   = ST_NO_HEX;
          do_idle    = 1'b1;
        end
      end
      MODE_HEXRUN, MODE_OCTRUN: begin
        if (digit_ok) begin
          digit_value_next      = acc[7:0];
          value_overflowed_next = value_overflowed || (acc[11:8] != 4'h0);
          byte_count_next       = count_inc;
        end else begin
          pre_v      = 1'b1;
          pre_r.ch   = value_overflowed ? CH_MAX : digit_value;
          pre_r.st   = value_overflowed ? ST_RANGE : ST_OK;
          pre_r.used = byte_count;
          do_idle    = 1'b1;
        end
      end
      default: do_idle = 1'b1;
    endcase

    idle_r = '0;
    if (q_item.is_zero) begin
      idle_r.st = ST_EMPTY;
    end else begin
      idle_r.ch   = q_item.byte_val;
      idle_r.st   = ST_OK;
      idle_r.used = 8'd1;
    end
    idle_v = do_idle && !q_item.is_bslash;
    if (do_idle) begin
      digit_value_next      = 8'h00;
      value_overflowed_next = 1'b0;
      byte_count_next       = q_item.is_bslash ? 8'd1 : 8'd0;
    end

    slot0      = pre_v ? pre_r : idle_r;
    slot0.last = !(pre_v && idle_v);
    slot1      = idle_r;
    slot1.last = 1'b1;
    n_write    = {1'b0, pre_v} + {1'b0, idle_v};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode             <= MODE_IDLE;
      digit_value      <= 8'h00;
      value_overflowed <= 1'b0;
      byte_count       <= 8'h00;
    end else if (pop) begin
      mode             <= mode_next;
      digit_value      <= digit_value_next;
      value_overflowed <= value_overflowed_next;
      byte_count       <= byte_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      res_count <= '0;
    end else begin
      if (pop) begin
        wr_ptr <= wr_ptr + RES_PW'(n_write);
      end
      if (take) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      res_count <= res_count + (pop ? RES_CW'(n_write) : '0) - RES_CW'(take);
    end
  end

  always_ff @(posedge clk) begin
    if (pop && (n_write != 2'd0)) begin
      res_mem[wr_ptr] <= slot0;
    end
    if (pop && (n_write == 2'd2)) begin
      res_mem[wr_ptr + 1'b1] <= slot1;
    end
  end

  assign out_valid    = (res_count != '0);
  assign decoded_char = $signed(res_mem[rd_ptr].ch);
  assign status       = res_mem[rd_ptr].st;
  assign bytes_used   = res_mem[rd_ptr].used;
  assign last_of_run  = res_mem[rd_ptr].last;

endmodule

/* design/c_escape_char_decoder_top.sv */
// ----------------------------------------------------------------------------
// c_escape_char_decoder_top
// Streaming decoder of C character escapes, one text byte per transfer.
// ----------------------------------------------------------------------------
// Accepts one text byte per cycle and returns one decoded character per
// cycle while neither side stalls. Most bytes give zero or one result. A
// byte that ends a digit run (or a non-hex byte after x) gives two, unless
// that byte is a backslash. Those two leave the result port one after the
// other, which is what sets the sustained rate: one byte per cycle while
// results average one per byte or fewer. A byte passes the input register,
// the classified-byte queue and the parser, which writes its results to a
// four-entry result buffer; its first result is offered from there. The
// queue and the result buffer let either side stall independently.
module c_escape_char_decoder_top
  import ced_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        text_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic signed [7:0] decoded_char,
  output logic [1:0]        status,
  output logic [7:0]        bytes_used,
  output logic              last_of_run
);

  logic  f_valid;
  item_t f_item;
  logic  q_ready;
  logic  q_valid;
  item_t q_item;
  logic  pop;

  ced_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .text_byte (text_byte),
    .f_valid   (f_valid),
    .f_item    (f_item),
    .q_ready   (q_ready)
  );

  ced_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (f_valid),
    .push_item (f_item),
    .ready     (q_ready),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .pop       (pop)
  );

  ced_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .decoded_char (decoded_char),
    .status       (status),
    .bytes_used   (bytes_used),
    .last_of_run  (last_of_run)
  );

endmodule

/* design/ced_checker.sv */
// ----------------------------------------------------------------------------
// ced_checker
// Port-level checks of the decoder, bound to the top level.
// ----------------------------------------------------------------------------
module ced_checker
  import ced_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic [7:0]        text_byte,
  input logic              out_valid,
  input logic              out_stall,
  input logic signed [7:0] decoded_char,
  input logic [1:0]        status,
  input logic [7:0]        bytes_used,
  input logic              last_of_run
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(decoded_char) && $stable(status) &&
      $stable(bytes_used) && $stable(last_of_run))
    else $error("stalled result changed");

  a_no_hex: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_NO_HEX) |-> (decoded_char == 8'sd0) &&
      (bytes_used == 8'd0))
    else $error("bad missing-hex result");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_EMPTY) |-> (decoded_char == 8'sd0) &&
      (bytes_used == 8'd0) && last_of_run)
    else $error("bad empty-input result");

  a_used: assert property (@(posedge clk) disable iff (rst)
    out_valid && ((status == ST_OK) || (status == ST_RANGE)) |-> (bytes_used != 8'd0))
    else $error("decoded character used no bytes");

endmodule

bind c_escape_char_decoder_top ced_checker u_ced_checker (.*);
